### design/sclk_pkg.sv
// Shared codes, widths and helper functions of the settable clock with stopwatch.
package sclk_pkg;

	// Display and sequencer modes.
	localparam logic [2:0] MODE_RUN       = 3'd0;
	localparam logic [2:0] MODE_SET_HOURS = 3'd1;
	localparam logic [2:0] MODE_SET_MINS  = 3'd2;
	localparam logic [2:0] MODE_SET_SECS  = 3'd3;
	localparam logic [2:0] MODE_WATCH     = 3'd4;

	// Stopwatch phases.
	localparam logic [1:0] PHASE_IDLE    = 2'd0;
	localparam logic [1:0] PHASE_RUNNING = 2'd1;
	localparam logic [1:0] PHASE_STOPPED = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_HOLD_DELAY   = 2'd0;
	localparam logic [1:0] CFG_REPEAT       = 2'd1;
	localparam logic [1:0] CFG_BLINK_PERIOD = 2'd2;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 8;

	// Register values after reset.
	localparam logic [7:0] HOLD_DELAY_RST   = 8'd100;
	localparam logic [5:0] REPEAT_RST       = 6'd50;
	localparam logic [5:0] BLINK_PERIOD_RST = 6'd60;

	// Counter limits.
	localparam logic [7:0] HUND_LIMIT  = 8'd100;
	localparam logic [7:0] SEC_LIMIT   = 8'd60;
	localparam logic [7:0] MIN_LIMIT   = 8'd60;
	localparam logic [7:0] HOUR_LIMIT  = 8'd24;
	localparam logic [7:0] WMIN_LIMIT  = 8'd100;

	// True when one more than the value reaches the limit.
	function automatic logic wraps(input logic [6:0] v, input logic [7:0] lim);
		logic [7:0] sum;
		sum = {1'b0, v} + 8'd1;
		return (sum >= lim);
	endfunction

	// One more than the value, back to zero at the limit.
	function automatic logic [6:0] wrap_inc(input logic [6:0] v, input logic [7:0] lim);
		logic [7:0] sum;
		sum = {1'b0, v} + 8'd1;
		return (sum >= lim) ? 7'd0 : sum[6:0];
	endfunction

endpackage

### design/settable_clock_with_stopwatch.sv
// Top level of the settable 24-hour clock with stopwatch, one tick word per cycle when not stalled.
// The result word for a tick appears in the cycle after the tick word is taken.
// Throughput: one tick word per cycle when not stalled; the next-state logic is a single
// pass of small increment and compare steps that load the state registers.
// Reset (arst_n low, asynchronous) clears the clock, stopwatch, counters and mode to
// zero and loads the hold delay, repeat period and blink period defaults.
module settable_clock_with_stopwatch (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration write port.
	input  logic                                cfg_write_en,
	input  logic [sclk_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [sclk_pkg::CFG_DATA_W-1:0]    cfg_data,
	// Tick channel.
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                mode_button,
	input  logic                                adjust_button,
	// Result channel.
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [2:0]                          mode_now,
	output logic [4:0]                          clock_hours,
	output logic [5:0]                          clock_minutes,
	output logic [5:0]                          clock_seconds,
	output logic [6:0]                          clock_hundredths,
	output logic [6:0]                          watch_minutes,
	output logic [5:0]                          watch_seconds,
	output logic [6:0]                          watch_hundredths,
	output logic                                watch_running,
	output logic [1:0]                          blank_field
);
	import sclk_pkg::*;

	// Configuration registers.
	logic [7:0] hold_delay_q;
	logic [5:0] repeat_period_q;
	logic [5:0] blink_period_q;

	// Clock, stopwatch and control state. The result word is read straight from these
	// registers, which only change when a new tick is taken and the previous word is gone.
	logic [2:0] mode_q;
	logic [4:0] hours_q;
	logic [5:0] minutes_q;
	logic [5:0] seconds_q;
	logic [6:0] hund_q;
	logic [6:0] wmin_q;
	logic [5:0] wsec_q;
	logic [6:0] whund_q;
	logic [1:0] phase_q;
	logic [7:0] hold_cnt_q;
	logic [5:0] repeat_cnt_q;
	logic [5:0] blink_cnt_q;
	logic       mode_prev_q;
	logic       adj_prev_q;
	logic [1:0] blank_q;
	logic       out_valid_q;

	// Next-state values.
	logic [2:0] mode_d;
	logic [4:0] hours_d;
	logic [5:0] minutes_d;
	logic [5:0] seconds_d;
	logic [6:0] hund_d;
	logic [6:0] wmin_d;
	logic [5:0] wsec_d;
	logic [6:0] whund_d;
	logic [1:0] phase_d;
	logic [7:0] hold_cnt_d;
	logic [5:0] repeat_cnt_d;
	logic [5:0] blink_cnt_d;
	logic [1:0] blank_d;

	logic accept;

	// A tick is taken whenever the result register is empty or being emptied this cycle.
	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;

	always_comb begin
		logic       mode_release;
		logic       adj_release;
		logic       auto_step;
		logic       set_mode;
		logic       bump;
		logic       c_sec;
		logic       c_min;
		logic       c_hour;
		logic       wc_sec;
		logic       wc_min;
		logic [5:0] rep_inc;
		logic [5:0] blink_inc;
		logic [6:0] sec_inc;
		logic [6:0] min_inc;
		logic [6:0] hour_inc;
		logic [6:0] wsec_inc;
		logic [6:0] hour_adj;
		logic [6:0] min_adj;
		logic [6:0] sec_adj;

		mode_release = mode_prev_q & ~mode_button;
		adj_release  = adj_prev_q & ~adjust_button;
		auto_step    = 1'b0;

		// Hold and auto-repeat counting. The hold count saturates at the delay and at
		// its own full scale; repeat counting starts once the delay has been reached.
		hold_cnt_d   = hold_cnt_q;
		repeat_cnt_d = repeat_cnt_q;
		rep_inc      = repeat_cnt_q + 6'd1;
		if (adjust_button) begin
			if ((hold_cnt_q < hold_delay_q) && (hold_cnt_q != 8'hFF)) begin
				hold_cnt_d = hold_cnt_q + 8'd1;
			end
			if (hold_cnt_d >= hold_delay_q) begin
				repeat_cnt_d = rep_inc;
				if (rep_inc >= repeat_period_q) begin
					auto_step    = 1'b1;
					repeat_cnt_d = 6'd0;
				end
			end
		end else begin
			hold_cnt_d   = 8'd0;
			repeat_cnt_d = 6'd0;
		end

		// The clock runs on every tick with full carry.
		c_sec    = wraps(hund_q, HUND_LIMIT);
		c_min    = c_sec & wraps({1'b0, seconds_q}, SEC_LIMIT);
		c_hour   = c_min & wraps({1'b0, minutes_q}, MIN_LIMIT);
		sec_inc  = wrap_inc({1'b0, seconds_q}, SEC_LIMIT);
		min_inc  = wrap_inc({1'b0, minutes_q}, MIN_LIMIT);
		hour_inc = wrap_inc({2'b0, hours_q}, HOUR_LIMIT);
		hund_d    = wrap_inc(hund_q, HUND_LIMIT);
		seconds_d = c_sec  ? sec_inc[5:0]  : seconds_q;
		minutes_d = c_min  ? min_inc[5:0]  : minutes_q;
		hours_d   = c_hour ? hour_inc[4:0] : hours_q;

		// The stopwatch runs if it was running when the tick arrived.
		wc_sec   = wraps(whund_q, HUND_LIMIT);
		wc_min   = wc_sec & wraps({1'b0, wsec_q}, SEC_LIMIT);
		wsec_inc = wrap_inc({1'b0, wsec_q}, SEC_LIMIT);
		wmin_d  = wmin_q;
		wsec_d  = wsec_q;
		whund_d = whund_q;
		if (phase_q == PHASE_RUNNING) begin
			whund_d = wrap_inc(whund_q, HUND_LIMIT);
			wsec_d  = wc_sec ? wsec_inc[5:0] : wsec_q;
			wmin_d  = wc_min ? wrap_inc(wmin_q, WMIN_LIMIT) : wmin_q;
		end

		// Adjust steps apply to the clock value after this tick's advance.
		hour_adj = wrap_inc({2'b0, hours_d}, HOUR_LIMIT);
		min_adj  = wrap_inc({1'b0, minutes_d}, MIN_LIMIT);
		sec_adj  = wrap_inc({1'b0, seconds_d}, SEC_LIMIT);

		// Set modes blink the chosen field and adjust it without carry. In stopwatch
		// mode each adjust release steps start, stop, then clear back to idle.
		set_mode    = (mode_q == MODE_SET_HOURS) || (mode_q == MODE_SET_MINS) ||
			(mode_q == MODE_SET_SECS);
		bump        = adj_release | auto_step;
		blink_cnt_d = blink_cnt_q;
		phase_d     = phase_q;
		blink_inc   = blink_cnt_q + 6'd1;
		if (set_mode) begin
			blink_cnt_d = (blink_inc >= blink_period_q) ? 6'd0 : blink_inc;
			if (bump) begin
				case (mode_q)
					MODE_SET_HOURS: hours_d   = hour_adj[4:0];
					MODE_SET_MINS:  minutes_d = min_adj[5:0];
					default:        seconds_d = sec_adj[5:0];
				endcase
			end
		end else if ((mode_q == MODE_WATCH) && adj_release) begin
			case (phase_q)
				PHASE_IDLE:    phase_d = PHASE_RUNNING;
				PHASE_RUNNING: phase_d = PHASE_STOPPED;
				default: begin
					phase_d = PHASE_IDLE;
					wmin_d  = 7'd0;
					wsec_d  = 6'd0;
					whund_d = 7'd0;
				end
			endcase
		end

		// The mode change comes last and restarts the blink cycle.
		mode_d = mode_q;
		if (mode_release) begin
			mode_d      = (mode_q >= MODE_WATCH) ? MODE_RUN : (mode_q + 3'd1);
			blink_cnt_d = 6'd0;
		end

		// The chosen field is hidden during the first half of the blink cycle.
		blank_d = 2'd0;
		if (((mode_d == MODE_SET_HOURS) || (mode_d == MODE_SET_MINS) ||
			(mode_d == MODE_SET_SECS)) && (blink_cnt_d < (blink_period_q >> 1))) begin
			blank_d = mode_d[1:0];
		end
	end

	// Configuration writes; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_delay_q    <= HOLD_DELAY_RST;
			repeat_period_q <= REPEAT_RST;
			blink_period_q  <= BLINK_PERIOD_RST;
		end else if (cfg_write_en) begin
			case (cfg_index)
				CFG_HOLD_DELAY:   hold_delay_q    <= cfg_data;
				CFG_REPEAT:       repeat_period_q <= cfg_data[5:0];
				CFG_BLINK_PERIOD: blink_period_q  <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// State and result registers advance together on each accepted tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_RUN;
			hours_q      <= '0;
			minutes_q    <= '0;
			seconds_q    <= '0;
			hund_q       <= '0;
			wmin_q       <= '0;
			wsec_q       <= '0;
			whund_q      <= '0;
			phase_q      <= PHASE_IDLE;
			hold_cnt_q   <= '0;
			repeat_cnt_q <= '0;
			blink_cnt_q  <= '0;
			mode_prev_q  <= 1'b0;
			adj_prev_q   <= 1'b0;
			blank_q      <= '0;
		end else if (accept) begin
			mode_q       <= mode_d;
			hours_q      <= hours_d;
			minutes_q    <= minutes_d;
			seconds_q    <= seconds_d;
			hund_q       <= hund_d;
			wmin_q       <= wmin_d;
			wsec_q       <= wsec_d;
			whund_q      <= whund_d;
			phase_q      <= phase_d;
			hold_cnt_q   <= hold_cnt_d;
			repeat_cnt_q <= repeat_cnt_d;
			blink_cnt_q  <= blink_cnt_d;
			mode_prev_q  <= mode_button;
			adj_prev_q   <= adjust_button;
			blank_q      <= blank_d;
		end
	end

	// The result word is valid from the tick that produced it until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid        = out_valid_q;
	assign mode_now         = mode_q;
	assign clock_hours      = hours_q;
	assign clock_minutes    = minutes_q;
	assign clock_seconds    = seconds_q;
	assign clock_hundredths = hund_q;
	assign watch_minutes    = wmin_q;
	assign watch_seconds    = wsec_q;
	assign watch_hundredths = whund_q;
	assign watch_running    = (phase_q == PHASE_RUNNING);
	assign blank_field      = blank_q;

endmodule
